>>> rtl/ilst_pkg.sv
package ilst_pkg;

	// Command codes carried by the func field.
	typedef enum logic [3:0] {
		FN_PUSH_HEAD = 4'd0,
		FN_PUSH_TAIL = 4'd1,
		FN_INSERT    = 4'd2,
		FN_GET       = 4'd3,
		FN_SET       = 4'd4,
		FN_POP_HEAD  = 4'd5,
		FN_POP_TAIL  = 4'd6,
		FN_REMOVE    = 4'd7,
		FN_FIND      = 4'd8,
		FN_SWAP      = 4'd9
	} func_t;

	// Completion codes carried by the status field.
	typedef enum logic [2:0] {
		STAT_OK        = 3'd0,
		STAT_BAD_INDEX = 3'd1,
		STAT_EMPTY     = 3'd2,
		STAT_FULL      = 3'd3,
		STAT_NOT_FOUND = 3'd4
	} status_t;

	// Sequencer states.
	typedef enum logic [2:0] {
		S_IDLE,
		S_MOVE,
		S_FINAL_WR,
		S_SWAP_RD1,
		S_SWAP_RD2,
		S_SWAP_WR1,
		S_SWAP_WR2,
		S_RESULT
	} state_t;

	localparam logic [31:0] FAIL_VALUE = 32'hFFFF_FFFF;

endpackage

>>> rtl/ilst_ram.sv
// Single-port-write, single-port-read RAM with a registered read.
module ilst_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64,
	parameter int ADDR_WIDTH = $clog2(DEPTH)
) (
	input  logic                  clk,
	input  logic                  wr_en,
	input  logic [ADDR_WIDTH-1:0] wr_addr,
	input  logic [WIDTH-1:0]      wr_data,
	input  logic [ADDR_WIDTH-1:0] rd_addr,
	output logic [WIDTH-1:0]      rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data <= mem_q[rd_addr];
	end

endmodule

>>> rtl/indexed_list_engine.sv
// Indexed list engine: a bounded, ordered list of signed words held in one on-chip RAM
// of CAPACITY entries of DATA_WIDTH bits. Each command transaction (push head, push tail,
// insert, get, set, pop head, pop tail, remove, find, swap) returns exactly one response
// transaction with a status, a value and the entry count after the command. The block
// works on one command at a time: cmd_stall is high from the cycle after a command is
// accepted until its response has been loaded into the output register, so a new
// command can be taken while an earlier response still waits on rsp_stall. The RAM
// moves or scans one entry per cycle, and a command that fails its checks goes straight
// to the result state without any RAM work. Values are stored in DATA_WIDTH bits
// (sign-extended or truncated on the way in) and returned sign-extended to 32 bits. No
// clearing pass is needed after reset: only entries below the count are ever read, and
// those have always been written.
module indexed_list_engine #(
	parameter int CAPACITY   = 64,
	parameter int DATA_WIDTH = 32
) (
	input  logic               clk,
	input  logic               arst_n,
	// Command channel.
	input  logic               cmd_valid,
	output logic               cmd_stall,
	input  logic [3:0]         func,
	input  logic [5:0]         position,
	input  logic [5:0]         second_position,
	input  logic signed [31:0] item_value,
	// Response channel.
	output logic               rsp_valid,
	input  logic               rsp_stall,
	output logic [2:0]         status,
	output logic signed [31:0] result_value,
	output logic [6:0]         entry_count
);

	localparam int AW = $clog2(CAPACITY);
	localparam int OW = $clog2(CAPACITY + 1);
	// Common width for comparing the 6-bit positions against the count.
	localparam int PW = (OW > 6) ? OW : 6;

	// Sign-extend or truncate a 32-bit value into the stored width.
	function automatic logic [DATA_WIDTH-1:0] store_word(input logic [31:0] v);
		logic [DATA_WIDTH-1:0] w;
		for (int j = 0; j < DATA_WIDTH; j++) begin
			if (j < 32) begin
				w[j] = v[j];
			end else begin
				w[j] = v[31];
			end
		end
		return w;
	endfunction

	// Sign-extend a stored word and keep 32 bits of it.
	function automatic logic [31:0] read_word(input logic [DATA_WIDTH-1:0] w);
		logic [31:0] r;
		for (int j = 0; j < 32; j++) begin
			if (j < DATA_WIDTH) begin
				r[j] = w[j];
			end else begin
				r[j] = w[DATA_WIDTH-1];
			end
		end
		return r;
	endfunction

	ilst_pkg::state_t  state_q, state_d;
	ilst_pkg::func_t   func_c;
	ilst_pkg::status_t dec_status;
	logic              dec_go;

	logic [OW-1:0] occ_q;
	logic [PW-1:0] occ_ext, p1_ext, p2_ext, ins_pos, mv_pos;
	logic          is_ins, is_rm, accept;

	// Walk control for shifts and scans.
	logic [AW-1:0] ptr_q;
	logic [OW-1:0] rem_q;
	logic          up_q, wr_q, find_q, first_q;
	logic          issue, hit;

	// Read pipeline stage.
	logic          mv_valid_s1, mv_first_s1;
	logic [AW-1:0] mv_addr_s1;

	logic [AW-1:0]         fin_addr_q, sw_addr_q;
	logic [DATA_WIDTH-1:0] hold_q;
	logic [31:0]           val_q;

	ilst_pkg::status_t res_status_q;
	logic [31:0]       res_value_q;

	// Output register.
	logic              rsp_valid_q;
	ilst_pkg::status_t out_status_q;
	logic [31:0]       out_value_q;
	logic [6:0]        out_count_q;
	logic              out_free;

	// RAM port.
	logic                  ram_we;
	logic [AW-1:0]         ram_waddr, ram_raddr;
	logic [DATA_WIDTH-1:0] ram_wdata, ram_rdata;

	ilst_ram #(
		.WIDTH (DATA_WIDTH),
		.DEPTH (CAPACITY)
	) u_ram (
		.clk     (clk),
		.wr_en   (ram_we),
		.wr_addr (ram_waddr),
		.wr_data (ram_wdata),
		.rd_addr (ram_raddr),
		.rd_data (ram_rdata)
	);

	assign func_c  = ilst_pkg::func_t'(func);
	assign occ_ext = PW'(occ_q);
	assign p1_ext  = PW'(position);
	assign p2_ext  = PW'(second_position);
	assign accept  = (state_q == ilst_pkg::S_IDLE) && cmd_valid;
	assign out_free = !rsp_valid_q || !rsp_stall;

	assign is_ins = (func_c == ilst_pkg::FN_PUSH_HEAD) || (func_c == ilst_pkg::FN_PUSH_TAIL) ||
		(func_c == ilst_pkg::FN_INSERT);
	assign is_rm = (func_c == ilst_pkg::FN_POP_HEAD) || (func_c == ilst_pkg::FN_POP_TAIL) ||
		(func_c == ilst_pkg::FN_REMOVE);

	// Position where a command starts its work in the RAM.
	always_comb begin
		case (func_c)
			ilst_pkg::FN_PUSH_HEAD: ins_pos = '0;
			ilst_pkg::FN_PUSH_TAIL: ins_pos = occ_ext;
			default:                ins_pos = p1_ext;
		endcase
		if (is_ins) begin
			mv_pos = ins_pos;
		end else if (func_c == ilst_pkg::FN_POP_HEAD || func_c == ilst_pkg::FN_FIND) begin
			mv_pos = '0;
		end else if (func_c == ilst_pkg::FN_POP_TAIL) begin
			mv_pos = occ_ext - PW'(1);
		end else begin
			mv_pos = p1_ext;
		end
	end

	// Command checks done at accept time; dec_go means RAM work follows.
	always_comb begin
		dec_status = ilst_pkg::STAT_OK;
		dec_go     = 1'b1;
		unique case (func_c) inside
			ilst_pkg::FN_PUSH_HEAD, ilst_pkg::FN_PUSH_TAIL, ilst_pkg::FN_INSERT: begin
				if (ins_pos > occ_ext) begin
					dec_status = ilst_pkg::STAT_BAD_INDEX;
					dec_go     = 1'b0;
				end else if (occ_q == OW'(CAPACITY)) begin
					dec_status = ilst_pkg::STAT_FULL;
					dec_go     = 1'b0;
				end
			end
			ilst_pkg::FN_GET, ilst_pkg::FN_SET, ilst_pkg::FN_REMOVE: begin
				if (p1_ext >= occ_ext) begin
					dec_status = ilst_pkg::STAT_BAD_INDEX;
					dec_go     = 1'b0;
				end
			end
			ilst_pkg::FN_POP_HEAD, ilst_pkg::FN_POP_TAIL: begin
				if (occ_q == '0) begin
					dec_status = ilst_pkg::STAT_EMPTY;
					dec_go     = 1'b0;
				end
			end
			ilst_pkg::FN_FIND: begin
				// Assume a miss until the scan finds a match.
				dec_status = ilst_pkg::STAT_NOT_FOUND;
			end
			ilst_pkg::FN_SWAP: begin
				if (p1_ext >= occ_ext || p2_ext >= occ_ext) begin
					dec_status = ilst_pkg::STAT_BAD_INDEX;
					dec_go     = 1'b0;
				end
			end
			default: begin
				dec_status = ilst_pkg::STAT_BAD_INDEX;
				dec_go     = 1'b0;
			end
		endcase
	end

	// A find stops at the first stored word equal to the search value.
	assign hit   = (state_q == ilst_pkg::S_MOVE) && mv_valid_s1 && find_q &&
		(read_word(ram_rdata) == val_q);
	assign issue = (state_q == ilst_pkg::S_MOVE) && (rem_q != '0) && !hit;

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ilst_pkg::S_IDLE: begin
				if (cmd_valid) begin
					if (!dec_go) begin
						state_d = ilst_pkg::S_RESULT;
					end else if (func_c == ilst_pkg::FN_SET) begin
						state_d = ilst_pkg::S_FINAL_WR;
					end else if (func_c == ilst_pkg::FN_SWAP) begin
						state_d = ilst_pkg::S_SWAP_RD1;
					end else begin
						state_d = ilst_pkg::S_MOVE;
					end
				end
			end
			ilst_pkg::S_MOVE: begin
				if (hit || (rem_q == '0 && !mv_valid_s1)) begin
					state_d = up_q ? ilst_pkg::S_FINAL_WR : ilst_pkg::S_RESULT;
				end
			end
			ilst_pkg::S_FINAL_WR: state_d = ilst_pkg::S_RESULT;
			ilst_pkg::S_SWAP_RD1: state_d = ilst_pkg::S_SWAP_RD2;
			ilst_pkg::S_SWAP_RD2: state_d = ilst_pkg::S_SWAP_WR1;
			ilst_pkg::S_SWAP_WR1: state_d = ilst_pkg::S_SWAP_WR2;
			ilst_pkg::S_SWAP_WR2: state_d = ilst_pkg::S_RESULT;
			ilst_pkg::S_RESULT: begin
				if (out_free) begin
					state_d = ilst_pkg::S_IDLE;
				end
			end
			default: state_d = ilst_pkg::S_IDLE;
		endcase
	end

	// State outputs: RAM control and the command stall.
	always_comb begin
		cmd_stall = (state_q != ilst_pkg::S_IDLE);
		ram_we    = 1'b0;
		ram_waddr = fin_addr_q;
		ram_wdata = store_word(val_q);
		ram_raddr = ptr_q;
		unique case (state_q)
			ilst_pkg::S_MOVE: begin
				// Each word read last cycle lands one place up or down.
				ram_we    = mv_valid_s1 && wr_q && !mv_first_s1;
				ram_waddr = up_q ? AW'(mv_addr_s1 + AW'(1)) : AW'(mv_addr_s1 - AW'(1));
				ram_wdata = ram_rdata;
			end
			ilst_pkg::S_FINAL_WR: begin
				ram_we = 1'b1;
			end
			ilst_pkg::S_SWAP_RD2: begin
				ram_raddr = sw_addr_q;
			end
			ilst_pkg::S_SWAP_WR1: begin
				ram_we    = 1'b1;
				ram_waddr = ptr_q;
				ram_wdata = ram_rdata;
			end
			ilst_pkg::S_SWAP_WR2: begin
				ram_we    = 1'b1;
				ram_waddr = sw_addr_q;
				ram_wdata = hold_q;
			end
			default: begin
			end
		endcase
	end

	// Control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ilst_pkg::S_IDLE;
			occ_q       <= '0;
			mv_valid_s1 <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			mv_valid_s1 <= issue;
			if (accept && dec_go) begin
				if (is_ins) begin
					occ_q <= occ_q + OW'(1);
				end else if (is_rm) begin
					occ_q <= occ_q - OW'(1);
				end
			end
			if (state_q == ilst_pkg::S_RESULT && out_free) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		if (accept) begin
			val_q        <= item_value;
			res_status_q <= dec_status;
			res_value_q  <= (dec_status == ilst_pkg::STAT_OK) ? '0 : ilst_pkg::FAIL_VALUE;
			// Inserts walk down from the top entry; everything else walks up.
			ptr_q        <= is_ins ? AW'(occ_ext - PW'(1)) : AW'(mv_pos);
			rem_q        <= (func_c == ilst_pkg::FN_GET) ? OW'(1) : OW'(occ_ext - mv_pos);
			up_q         <= is_ins;
			wr_q         <= !(func_c == ilst_pkg::FN_GET || func_c == ilst_pkg::FN_FIND);
			find_q       <= (func_c == ilst_pkg::FN_FIND);
			first_q      <= !is_ins;
			fin_addr_q   <= AW'(mv_pos);
			sw_addr_q    <= AW'(p2_ext);
		end
		if (issue) begin
			ptr_q   <= up_q ? AW'(ptr_q - AW'(1)) : AW'(ptr_q + AW'(1));
			rem_q   <= rem_q - OW'(1);
			first_q <= 1'b0;
		end
		mv_addr_s1  <= ptr_q;
		mv_first_s1 <= first_q;
		if (state_q == ilst_pkg::S_MOVE && mv_valid_s1) begin
			if (hit) begin
				res_status_q <= ilst_pkg::STAT_OK;
				res_value_q  <= 32'(mv_addr_s1);
			end else if (mv_first_s1 && !find_q) begin
				res_value_q <= read_word(ram_rdata);
			end
		end
		if (state_q == ilst_pkg::S_SWAP_RD2) begin
			hold_q <= ram_rdata;
		end
		if (state_q == ilst_pkg::S_RESULT && out_free) begin
			out_status_q <= res_status_q;
			out_value_q  <= res_value_q;
			out_count_q  <= 7'(occ_q);
		end
	end

	assign rsp_valid    = rsp_valid_q;
	assign status       = out_status_q;
	assign result_value = out_value_q;
	assign entry_count  = out_count_q;

endmodule

>>> bench/indexed_list_engine_test.sv
// Self-checking bench for the indexed list engine.
//
// Each command transaction that the block accepts is applied at once to a shadow list
// kept here as a queue of words. The shadow list yields the status, value and count
// that the block must return, and these wait in a queue until the matching response
// transaction arrives. Responses come back strictly in command order, so every
// accepted response is compared with the oldest waiting expectation.
module indexed_list_engine_test;

	localparam int LIST_DEPTH  = 64;
	localparam int RUN_ITEMS   = 750;
	localparam int PHASE_LEN   = 125;
	localparam int DRAIN_WAIT  = 100;
	localparam int HOLD_CYCLES = 400;
	localparam int HOLD_AT     = 200;

	// Random phases: the list is pushed toward full, churned, then drained to empty.
	localparam int PH_GROW   = 0;
	localparam int PH_MIXED  = 1;
	localparam int PH_SHRINK = 2;

	// One command as the sender offers it. The gap is the number of idle cycles the
	// sender leaves before the command is offered.
	typedef struct packed {
		logic [3:0]         func;
		logic [5:0]         pos;
		logic [5:0]         pos2;
		logic signed [31:0] value;
		int                 gap;
	} list_cmd_t;

	typedef struct packed {
		ilst_pkg::status_t  status;
		logic signed [31:0] value;
		logic [6:0]         count;
	} list_rsp_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               cmd_valid = 1'b0;
	logic               cmd_stall;
	logic [3:0]         func = '0;
	logic [5:0]         position = '0;
	logic [5:0]         second_position = '0;
	logic signed [31:0] item_value = '0;
	logic               rsp_valid;
	logic               rsp_stall = 1'b0;
	logic [2:0]         status;
	logic signed [31:0] result_value;
	logic [6:0]         entry_count;

	// Shadow contents of the list, head at index 0.
	logic signed [31:0] shadow_list[$];
	list_rsp_t          pending_rsp_q[$];
	list_cmd_t          command_q[$];
	list_cmd_t          offered;

	int issued_total   = 0;
	int accepted_total = 0;
	int checked_total  = 0;
	int error_count    = 0;

	indexed_list_engine dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd_valid       (cmd_valid),
		.cmd_stall       (cmd_stall),
		.func            (func),
		.position        (position),
		.second_position (second_position),
		.item_value      (item_value),
		.rsp_valid       (rsp_valid),
		.rsp_stall       (rsp_stall),
		.status          (status),
		.result_value    (result_value),
		.entry_count     (entry_count)
	);

	initial begin
		forever #6 clk = ~clk;
	end

	// Generous ceiling: several times the slowest legal run.
	initial begin
		#10000000;
		$display("status: fail");
		$finish;
	end

	task automatic report_mismatch(input string what);
		error_count++;
		$display("mismatch at response %0d: %s", checked_total, what);
	endtask

	// Applies one accepted command to the shadow list and queues the response it must
	// produce. Failing commands leave the list untouched and return the all-ones value.
	task automatic apply_list_command(input list_cmd_t c);
		list_rsp_t          r;
		logic signed [31:0] tmp;
		int                 n;
		int                 at;
		int                 i;
		n = shadow_list.size();
		r.status = ilst_pkg::STAT_OK;
		r.value = '0;
		case (c.func) inside
			ilst_pkg::FN_PUSH_HEAD, ilst_pkg::FN_PUSH_TAIL, ilst_pkg::FN_INSERT: begin
				at = (c.func == ilst_pkg::FN_PUSH_HEAD) ? 0 :
					(c.func == ilst_pkg::FN_PUSH_TAIL) ? n : int'(c.pos);
				// The index check wins over the full check.
				if (at > n) begin
					r.status = ilst_pkg::STAT_BAD_INDEX;
					r.value = ilst_pkg::FAIL_VALUE;
				end else if (n >= LIST_DEPTH) begin
					r.status = ilst_pkg::STAT_FULL;
					r.value = ilst_pkg::FAIL_VALUE;
				end else begin
					shadow_list.insert(at, c.value);
				end
			end
			ilst_pkg::FN_GET, ilst_pkg::FN_SET, ilst_pkg::FN_REMOVE: begin
				if (int'(c.pos) >= n) begin
					r.status = ilst_pkg::STAT_BAD_INDEX;
					r.value = ilst_pkg::FAIL_VALUE;
				end else if (c.func == ilst_pkg::FN_GET) begin
					r.value = shadow_list[c.pos];
				end else if (c.func == ilst_pkg::FN_SET) begin
					shadow_list[c.pos] = c.value;
				end else begin
					r.value = shadow_list[c.pos];
					shadow_list.delete(int'(c.pos));
				end
			end
			ilst_pkg::FN_POP_HEAD, ilst_pkg::FN_POP_TAIL: begin
				if (n == 0) begin
					r.status = ilst_pkg::STAT_EMPTY;
					r.value = ilst_pkg::FAIL_VALUE;
				end else begin
					at = (c.func == ilst_pkg::FN_POP_HEAD) ? 0 : n - 1;
					r.value = shadow_list[at];
					shadow_list.delete(at);
				end
			end
			ilst_pkg::FN_FIND: begin
				r.status = ilst_pkg::STAT_NOT_FOUND;
				r.value = ilst_pkg::FAIL_VALUE;
				// Scanning from the tail leaves the first match as the last one recorded.
				for (i = n - 1; i >= 0; i--) begin
					if (shadow_list[i] == c.value) begin
						r.status = ilst_pkg::STAT_OK;
						r.value = i;
					end
				end
			end
			ilst_pkg::FN_SWAP: begin
				if (int'(c.pos) >= n || int'(c.pos2) >= n) begin
					r.status = ilst_pkg::STAT_BAD_INDEX;
					r.value = ilst_pkg::FAIL_VALUE;
				end else begin
					tmp = shadow_list[c.pos];
					shadow_list[c.pos] = shadow_list[c.pos2];
					shadow_list[c.pos2] = tmp;
				end
			end
			default: begin
				// Codes above swap are ignored by the block but still answered.
				r.status = ilst_pkg::STAT_BAD_INDEX;
				r.value = ilst_pkg::FAIL_VALUE;
			end
		endcase
		r.count = 7'(shadow_list.size());
		pending_rsp_q.push_back(r);
	endtask

	// Mostly no idling, often a short burst, now and then a long one.
	function automatic int pick_idle_length();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// Sender. A command stays on the port until it is accepted; only then does the
	// sender move on, idling first for the gap that the next command carries.
	int gap_served = 0;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmd_valid <= 1'b0;
			gap_served = 0;
		end else begin
			if (cmd_valid && !cmd_stall) begin
				apply_list_command(offered);
				accepted_total++;
			end
			if (!(cmd_valid && cmd_stall)) begin
				if (command_q.size() == 0) begin
					cmd_valid <= 1'b0;
				end else if (gap_served < command_q[0].gap) begin
					gap_served++;
					cmd_valid <= 1'b0;
				end else begin
					offered = command_q.pop_front();
					gap_served = 0;
					cmd_valid <= 1'b1;
					func <= offered.func;
					position <= offered.pos;
					second_position <= offered.pos2;
					item_value <= offered.value;
				end
			end
		end
	end

	// Receiver. It checks every accepted response and then decides whether to stall
	// in the next cycle. Once, after HOLD_AT responses, it holds off for a long stretch
	// so that the block parks a response, takes one more command and stalls its input
	// while the sender keeps offering.
	int  stall_left = 0;
	int  hold_left  = 0;
	bit  hold_done  = 1'b0;
	list_rsp_t want;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_stall <= 1'b0;
		end else begin
			if (rsp_valid && !rsp_stall) begin
				if (pending_rsp_q.size() == 0) begin
					report_mismatch("response with no command outstanding");
				end else begin
					want = pending_rsp_q.pop_front();
					if (status !== want.status)
						report_mismatch($sformatf("status got %0d want %0d",
							status, want.status));
					if (result_value !== want.value)
						report_mismatch($sformatf("result_value got %0d want %0d",
							result_value, want.value));
					if (entry_count !== want.count)
						report_mismatch($sformatf("entry_count got %0d want %0d",
							entry_count, want.count));
				end
				checked_total++;
			end
			if (!hold_done && checked_total >= HOLD_AT) begin
				hold_done = 1'b1;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				rsp_stall <= 1'b1;
			end else begin
				// Every fourth stretch of responses runs without any stalls.
				if (stall_left == 0 && (checked_total / 80) % 4 != 3)
					stall_left = pick_idle_length();
				rsp_stall <= (stall_left > 0);
				if (stall_left > 0)
					stall_left--;
			end
		end
	end

	// Entry count after a command, used only to aim random indexes near the live range.
	function automatic int count_after(input list_cmd_t c, input int n);
		case (c.func) inside
			ilst_pkg::FN_PUSH_HEAD, ilst_pkg::FN_PUSH_TAIL:
				return (n < LIST_DEPTH) ? n + 1 : n;
			ilst_pkg::FN_INSERT:
				return (int'(c.pos) <= n && n < LIST_DEPTH) ? n + 1 : n;
			ilst_pkg::FN_POP_HEAD, ilst_pkg::FN_POP_TAIL:
				return (n > 0) ? n - 1 : n;
			ilst_pkg::FN_REMOVE:
				return (int'(c.pos) < n) ? n - 1 : n;
			default:
				return n;
		endcase
	endfunction

	// A small pool of values, so that finds hit and duplicates appear in the list.
	function automatic logic signed [31:0] pick_value();
		logic signed [31:0] pool[8];
		pool = '{32'sd0, -32'sd1, 32'sd1, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sd5, 32'sd42,
			32'sh55AA_55AA};
		if ($urandom_range(0, 2) == 0)
			return $urandom;
		return pool[$urandom_range(0, 7)];
	endfunction

	function automatic logic [5:0] pick_index(input int n);
		if ($urandom_range(0, 3) == 0)
			return 6'($urandom_range(0, 63));
		return 6'($urandom_range(0, (n > 63) ? 63 : n));
	endfunction

	function automatic list_cmd_t random_command(input int phase, input int n, input bit quiet);
		list_cmd_t c;
		int        grow_share;
		int        shrink_share;
		int        r;
		grow_share = (phase == PH_GROW) ? 65 : (phase == PH_SHRINK) ? 10 : 30;
		shrink_share = (phase == PH_SHRINK) ? 65 : (phase == PH_GROW) ? 10 : 30;
		r = $urandom_range(0, 99);
		if (r < grow_share) begin
			case ($urandom_range(0, 2))
				0:       c.func = ilst_pkg::FN_PUSH_HEAD;
				1:       c.func = ilst_pkg::FN_PUSH_TAIL;
				default: c.func = ilst_pkg::FN_INSERT;
			endcase
		end else if (r < grow_share + shrink_share) begin
			case ($urandom_range(0, 2))
				0:       c.func = ilst_pkg::FN_POP_HEAD;
				1:       c.func = ilst_pkg::FN_POP_TAIL;
				default: c.func = ilst_pkg::FN_REMOVE;
			endcase
		end else begin
			case ($urandom_range(0, 24))
				0:                c.func = 4'($urandom_range(10, 15));
				1, 2, 3, 4, 5, 6: c.func = ilst_pkg::FN_GET;
				7, 8, 9, 10, 11:  c.func = ilst_pkg::FN_SET;
				12, 13, 14, 15, 16, 17, 18: c.func = ilst_pkg::FN_FIND;
				default:          c.func = ilst_pkg::FN_SWAP;
			endcase
		end
		c.pos = pick_index(n);
		c.pos2 = pick_index(n);
		c.value = pick_value();
		c.gap = quiet ? 0 : pick_idle_length();
		return c;
	endfunction

	function automatic list_cmd_t directed(input ilst_pkg::func_t f, input logic [5:0] p,
		input logic [5:0] p2, input logic signed [31:0] v);
		list_cmd_t c;
		c.func = f;
		c.pos = p;
		c.pos2 = p2;
		c.value = v;
		c.gap = pick_idle_length();
		return c;
	endfunction

	task automatic queue_command(input list_cmd_t c);
		command_q.push_back(c);
		issued_total++;
	endtask

	// Stimulus and end of run.
	initial begin
		list_cmd_t c;
		int        planned_count;
		int        k;

		// Directed part: every failure on an empty list, each command but pop head once on a
		// short list, unknown codes, and removals down to an empty list again.
		queue_command(directed(ilst_pkg::FN_POP_HEAD, 6'd0, 6'd0, 32'sd0));
		queue_command(directed(ilst_pkg::FN_POP_TAIL, 6'd0, 6'd0, 32'sd0));
		queue_command(directed(ilst_pkg::FN_GET, 6'd0, 6'd0, 32'sd0));
		queue_command(directed(ilst_pkg::FN_FIND, 6'd0, 6'd0, 32'sd0));
		queue_command(directed(ilst_pkg::FN_SWAP, 6'd0, 6'd0, 32'sd0));
		queue_command(directed(ilst_pkg::FN_INSERT, 6'd1, 6'd0, 32'sd7));
		queue_command(directed(ilst_pkg::FN_REMOVE, 6'd0, 6'd0, 32'sd0));
		queue_command(directed(ilst_pkg::FN_SET, 6'd0, 6'd0, 32'sd9));
		queue_command(directed(ilst_pkg::FN_PUSH_HEAD, 6'd0, 6'd0, 32'sh7FFF_FFFF));
		queue_command(directed(ilst_pkg::FN_PUSH_TAIL, 6'd63, 6'd63, 32'sh8000_0000));
		queue_command(directed(ilst_pkg::FN_INSERT, 6'd1, 6'd0, -32'sd1));
		queue_command(directed(ilst_pkg::FN_INSERT, 6'd3, 6'd0, 32'sd0));
		queue_command(directed(ilst_pkg::FN_INSERT, 6'd63, 6'd0, 32'sd3));
		queue_command(directed(ilst_pkg::FN_GET, 6'd3, 6'd0, 32'sd0));
		queue_command(directed(ilst_pkg::FN_SET, 6'd0, 6'd0, 32'sh1234_5678));
		queue_command(directed(ilst_pkg::FN_FIND, 6'd0, 6'd0, -32'sd1));
		queue_command(directed(ilst_pkg::FN_SWAP, 6'd0, 6'd3, 32'sd0));
		queue_command(directed(ilst_pkg::FN_SWAP, 6'd2, 6'd2, 32'sd0));
		queue_command(directed(ilst_pkg::FN_SWAP, 6'd1, 6'd63, 32'sd0));
		queue_command(directed(ilst_pkg::func_t'(4'd15), 6'd63, 6'd63, 32'shFFFF_FFFF));
		queue_command(directed(ilst_pkg::func_t'(4'd10), 6'd0, 6'd0, 32'sd0));
		queue_command(directed(ilst_pkg::FN_REMOVE, 6'd1, 6'd0, 32'sd0));
		queue_command(directed(ilst_pkg::FN_POP_TAIL, 6'd0, 6'd0, 32'sd0));
		queue_command(directed(ilst_pkg::FN_REMOVE, 6'd0, 6'd0, 32'sd0));
		queue_command(directed(ilst_pkg::FN_POP_TAIL, 6'd0, 6'd0, 32'sd0));

		// Random part, in phases that fill the list until it overflows, churn it, and
		// empty it again, so that full and empty are both reached several times.
		planned_count = 0;
		for (k = 0; k < RUN_ITEMS; k++) begin
			c = random_command((k / PHASE_LEN) % 3, planned_count, (k / 60) % 4 == 1);
			planned_count = count_after(c, planned_count);
			queue_command(c);
		end

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		while (accepted_total < issued_total)
			@(negedge clk);
		while (pending_rsp_q.size() != 0)
			@(negedge clk);
		// Let any stray response show up before the verdict.
		repeat (DRAIN_WAIT) @(negedge clk);
		if (error_count == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule

>>> filelist.f
rtl/ilst_pkg.sv
rtl/ilst_ram.sv
rtl/indexed_list_engine.sv
bench/indexed_list_engine_test.sv
